@@ src/nhht_pkg.sv @@
// Shared types and constants of the next-hop hash table.
package nhht_pkg;

    localparam int ID_W     = 8;
    localparam int STATUS_W = 2;
    localparam int ID_SPAN  = 2 ** ID_W;

    localparam logic REQ_SET    = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_LOOKUP   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } nhht_state_t;

endpackage

@@ src/nhht_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module nhht_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 4,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/next_hop_hash_table_core.sv @@
// Top level of the next-hop hash table: sequencer, way compare unit and table memories.
//
// A request enters on the s_ channel (s_valid/s_ready). A set request (s_req_type 0)
// updates the entry of s_dest_id in its bucket, or inserts it into the lowest free way,
// or reports the bucket as full and drops the write. A lookup request (s_req_type 1)
// returns the stored next hop and a found flag. One result per request leaves on the
// m_ channel (m_valid/m_ready) with m_found, m_next_hop_out and m_status.
// The bucket is the masked destination ID modulo BUCKETS, taken from a constant table.
// A single comparator walks the ways of the bucket, one way per cycle, reading the
// entry memory through its registered read port; a last cycle writes the table back.
// The result is registered after the scan and update states, and the block takes a new
// request only once it is back in the idle state, after the previous one is finished.
// The result sits in an output register: the block accepts the next request while a
// result waits, and only holds the write-back cycle while the receiver stalls.
// After reset the valid bits are cleared row by row, one bucket per cycle;
// s_ready stays low until that sweep is done.
module next_hop_hash_table_core #(
    parameter int BUCKETS = 16,
    parameter int WAYS    = 4,
    parameter int ID_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [nhht_pkg::ID_W-1:0]     s_dest_id,
    input  logic [nhht_pkg::ID_W-1:0]     s_next_hop_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [nhht_pkg::ID_W-1:0]     m_next_hop_out,
    output logic [nhht_pkg::STATUS_W-1:0] m_status
);

    import nhht_pkg::*;

    localparam int BUCKET_W   = $clog2(BUCKETS);
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KEY_W      = ID_BITS;
    localparam int ENTRY_W    = 2 * KEY_W;
    localparam int DATA_AW    = BUCKET_W + WAY_W;
    localparam int DATA_DEPTH = BUCKETS * (2 ** WAY_W);
    localparam logic [ID_W-1:0] IN_MASK = ID_W'((1 << ID_BITS) - 1);

    typedef logic [ID_SPAN-1:0][BUCKET_W-1:0] bucket_lut_t;

    function automatic bucket_lut_t build_lut();
        bucket_lut_t lut;
        for (int k = 0; k < ID_SPAN; k++) begin
            lut[k] = BUCKET_W'(k % BUCKETS);
        end
        return lut;
    endfunction

    localparam bucket_lut_t BUCKET_LUT = build_lut();

    nhht_state_t state_reg, state_next;

    logic                  req_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      hop_reg;
    logic [BUCKET_W-1:0]   bucket_reg;
    logic [WAY_W-1:0]      way_reg;
    logic                  hit_reg;
    logic [WAY_W-1:0]      hit_way_reg;
    logic [KEY_W-1:0]      hit_hop_reg;
    logic                  free_reg;
    logic [WAY_W-1:0]      free_way_reg;
    logic [BUCKET_W-1:0]   clr_reg;
    logic                  m_valid_reg;
    logic                  m_found_reg;
    logic [ID_W-1:0]       m_hop_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    logic [ID_W-1:0]       in_key;
    logic [ID_W-1:0]       in_hop;
    logic [BUCKET_W-1:0]   in_bucket;
    logic                  s_accept;
    logic                  out_free;
    logic                  last_way;
    logic                  clr_done;
    logic                  cur_valid;
    logic                  cur_match;
    logic [KEY_W-1:0]      rd_dest;
    logic [KEY_W-1:0]      rd_hop;

    logic                  v_we;
    logic [BUCKET_W-1:0]   v_waddr;
    logic [WAYS-1:0]       v_wdata;
    logic                  v_re;
    logic [WAYS-1:0]       v_row;
    logic                  d_we;
    logic [DATA_AW-1:0]    d_waddr;
    logic [ENTRY_W-1:0]    d_wdata;
    logic                  d_re;
    logic [DATA_AW-1:0]    d_raddr;
    logic [ENTRY_W-1:0]    d_rdata;

    assign in_key    = s_dest_id & IN_MASK;
    assign in_hop    = s_next_hop_in & IN_MASK;
    assign in_bucket = BUCKET_LUT[in_key];
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_way  = (way_reg == WAY_W'(WAYS - 1));
    assign clr_done  = (clr_reg == BUCKET_W'(BUCKETS - 1));
    assign rd_dest   = d_rdata[ENTRY_W-1:KEY_W];
    assign rd_hop    = d_rdata[KEY_W-1:0];
    assign cur_valid = v_row[way_reg];
    assign cur_match = cur_valid && (rd_dest == key_reg);

    nhht_ram #(
        .DEPTH  (BUCKETS),
        .WIDTH  (WAYS),
        .ADDR_W (BUCKET_W)
    ) u_valid_ram (
        .aclk  (aclk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (in_bucket),
        .rdata (v_row)
    );

    nhht_ram #(
        .DEPTH  (DATA_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (DATA_AW)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .re    (d_re),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_way) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        v_we    = 1'b0;
        v_waddr = bucket_reg;
        v_wdata = v_row | (WAYS'(1) << free_way_reg);
        v_re    = 1'b0;
        d_we    = 1'b0;
        d_waddr = {bucket_reg, hit_way_reg};
        d_wdata = {key_reg, hop_reg};
        d_re    = 1'b0;
        d_raddr = {in_bucket, WAY_W'(0)};
        case (state_reg)
            ST_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = clr_reg;
                v_wdata = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                v_re    = s_accept;
                d_re    = s_accept;
            end
            ST_SCAN: begin
                d_re    = 1'b1;
                d_raddr = {bucket_reg, way_reg + WAY_W'(1)};
            end
            ST_UPDATE: begin
                if (out_free && (req_reg == REQ_SET)) begin
                    if (hit_reg) begin
                        d_we = 1'b1;
                    end else if (free_reg) begin
                        d_we    = 1'b1;
                        d_waddr = {bucket_reg, free_way_reg};
                        v_we    = 1'b1;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + BUCKET_W'(1);
            end
            if ((state_reg == ST_UPDATE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg    <= s_req_type;
            key_reg    <= KEY_W'(in_key);
            hop_reg    <= KEY_W'(in_hop);
            bucket_reg <= in_bucket;
            way_reg    <= '0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            way_reg <= way_reg + WAY_W'(1);
            if (cur_match && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_way_reg <= way_reg;
                hit_hop_reg <= rd_hop;
            end
            if (!cur_valid && !free_reg) begin
                free_reg     <= 1'b1;
                free_way_reg <= way_reg;
            end
        end
        if ((state_reg == ST_UPDATE) && out_free) begin
            m_found_reg <= hit_reg;
            if ((req_reg == REQ_LOOKUP) && hit_reg) begin
                m_hop_reg <= ID_W'(hit_hop_reg);
            end else begin
                m_hop_reg <= '0;
            end
            if (req_reg == REQ_LOOKUP) begin
                m_status_reg <= STATUS_LOOKUP;
            end else if (hit_reg) begin
                m_status_reg <= STATUS_UPDATED;
            end else if (free_reg) begin
                m_status_reg <= STATUS_INSERTED;
            end else begin
                m_status_reg <= STATUS_FULL;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_next_hop_out = m_hop_reg;
    assign m_status       = m_status_reg;

endmodule
